// ----- src/hbpe_pkg.sv -----
package hbpe_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_IN_W = 6;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } t_func;

    function automatic int code_w(input int max_len);
        return (max_len < WORD_W) ? max_len : WORD_W;
    endfunction

    function automatic int len_w(input int max_len);
        return $clog2(code_w(max_len) + 1);
    endfunction

    function automatic int entry_w(input int max_len);
        return 1 + len_w(max_len) + code_w(max_len);
    endfunction

endpackage

// ----- src/hbpe_fifo.sv -----
module hbpe_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// ----- src/hbpe_front.sv -----
module hbpe_front #(
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hbpe_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic [hbpe_pkg::FUNC_W-1:0]                 i_func,
    input  logic [hbpe_pkg::SYM_W-1:0]                  i_symbol,
    input  logic [hbpe_pkg::LEN_IN_W-1:0]               i_code_length,
    input  logic [hbpe_pkg::WORD_W-1:0]                 i_code_word,
    output logic                                        o_push,
    output logic [hbpe_pkg::entry_w(MAX_CODE_LEN)-1:0]  o_entry,
    input  logic                                        i_q_full
);
    import hbpe_pkg::*;

    localparam int CODE_W = code_w(MAX_CODE_LEN);
    localparam int LEN_W  = len_w(MAX_CODE_LEN);
    localparam int AW     = $clog2(SYMBOL_COUNT);

    logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_vld;
    logic [LEN_W+CODE_W-1:0] r_rd;
    logic                    r_rd_vld;
    logic                    r_flush;
    logic                    r_fv;

    logic              accept;
    logic              in_range;
    logic [AW-1:0]     addr;
    logic              is_load;
    logic              take;
    logic              n_flush;
    logic [LEN_W-1:0]  len_c;
    logic [LEN_W-1:0]  rd_len;
    logic [LEN_W-1:0]  e_len;
    logic [CODE_W-1:0] aligned;
    logic              need;
    logic              blocked;

    always_comb begin
        in_range = ({1'b0, i_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
        addr     = i_symbol[AW-1:0];
        is_load  = 1'b0;
        take     = 1'b0;
        n_flush  = 1'b0;
        case (i_func)
            FUNC_LOAD: begin
                is_load = in_range;
            end
            FUNC_ENCODE: begin
                take = in_range;
            end
            FUNC_FLUSH: begin
                take    = 1'b1;
                n_flush = 1'b1;
            end
            default: ;
        endcase
        if (i_code_length > LEN_IN_W'(CODE_W)) begin
            len_c = LEN_W'(CODE_W);
        end else begin
            len_c = i_code_length[LEN_W-1:0];
        end
    end

    always_comb begin
        rd_len  = r_rd_vld ? r_rd[CODE_W +: LEN_W] : '0;
        e_len   = r_flush ? '0 : rd_len;
        aligned = r_rd[CODE_W-1:0] << (LEN_W'(CODE_W) - rd_len);
        need    = r_flush || (e_len != '0);
        blocked = need && i_q_full;
    end

    assign o_stall = r_fv && blocked;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_fv && need && !i_q_full;
    assign o_entry = {r_flush, e_len, aligned};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv  <= 1'b0;
            r_vld <= '0;
        end else begin
            if (accept) begin
                r_fv <= take;
            end else if (r_fv && !blocked) begin
                r_fv <= 1'b0;
            end
            if (accept && is_load) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            mem[addr] <= {len_c, i_code_word[CODE_W-1:0]};
        end
        if (accept) begin
            r_rd     <= mem[addr];
            r_rd_vld <= r_vld[addr];
            r_flush  <= n_flush;
        end
    end

endmodule

// ----- src/hbpe_back.sv -----
module hbpe_back #(
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_q_valid,
    input  logic [hbpe_pkg::entry_w(MAX_CODE_LEN)-1:0]  i_q_entry,
    output logic                                        o_q_pop,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [hbpe_pkg::BYTE_W-1:0]                 o_out_byte,
    output logic                                        o_byte_valid,
    output logic [hbpe_pkg::PAD_W-1:0]                  o_pad_bits,
    output logic                                        o_is_final,
    output logic                                        o_last
);
    import hbpe_pkg::*;

    localparam int CODE_W = code_w(MAX_CODE_LEN);
    localparam int LEN_W  = len_w(MAX_CODE_LEN);
    localparam int ENT_W  = entry_w(MAX_CODE_LEN);
    localparam int BUF_W  = CODE_W + BYTE_W - 1;
    localparam int CNT_W  = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  r_buf;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte;
    logic              r_bv;
    logic [PAD_W-1:0]  r_pad;
    logic              r_fin;
    logic              r_last;

    logic [BUF_W-1:0]  n_buf;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_ov;
    logic [BYTE_W-1:0] n_byte;
    logic              n_bv;
    logic [PAD_W-1:0]  n_pad;
    logic              n_fin;
    logic              n_last;

    logic              free;
    logic              q_flush;
    logic [LEN_W-1:0]  q_len;
    logic [CODE_W-1:0] q_code;
    logic [BUF_W-1:0]  merged;
    logic [CNT_W-1:0]  cnt2;
    logic              has_byte;

    always_comb begin
        q_flush  = i_q_entry[ENT_W-1];
        q_len    = i_q_entry[CODE_W +: LEN_W];
        q_code   = i_q_entry[CODE_W-1:0];
        free     = !r_ov || !i_stall;
        merged   = r_buf | ({q_code, (BYTE_W-1)'(0)} >> r_cnt);
        cnt2     = r_cnt + CNT_W'(q_len);
        has_byte = (r_cnt >= CNT_W'(BYTE_W));
        o_q_pop  = free && !has_byte && i_q_valid;

        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_ov   = r_ov;
        n_byte = r_byte;
        n_bv   = r_bv;
        n_pad  = r_pad;
        n_fin  = r_fin;
        n_last = r_last;

        if (free) begin
            n_ov = 1'b0;
            if (has_byte) begin
                n_ov   = 1'b1;
                n_byte = r_buf[BUF_W-1 -: BYTE_W];
                n_bv   = 1'b1;
                n_pad  = '0;
                n_fin  = 1'b0;
                n_last = ({1'b0, r_cnt} < (CNT_W+1)'(2*BYTE_W));
                n_buf  = r_buf << BYTE_W;
                n_cnt  = r_cnt - CNT_W'(BYTE_W);
            end else if (i_q_valid) begin
                if (q_flush) begin
                    n_ov   = 1'b1;
                    n_byte = r_buf[BUF_W-1 -: BYTE_W];
                    n_bv   = (r_cnt != '0);
                    n_pad  = (r_cnt != '0) ? PAD_W'(CNT_W'(BYTE_W) - r_cnt) : '0;
                    n_fin  = 1'b1;
                    n_last = 1'b1;
                    n_buf  = '0;
                    n_cnt  = '0;
                end else if (cnt2 >= CNT_W'(BYTE_W)) begin
                    n_ov   = 1'b1;
                    n_byte = merged[BUF_W-1 -: BYTE_W];
                    n_bv   = 1'b1;
                    n_pad  = '0;
                    n_fin  = 1'b0;
                    n_last = ({1'b0, cnt2} < (CNT_W+1)'(2*BYTE_W));
                    n_buf  = merged << BYTE_W;
                    n_cnt  = cnt2 - CNT_W'(BYTE_W);
                end else begin
                    n_buf = merged;
                    n_cnt = cnt2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_ov  <= n_ov;
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bv   <= n_bv;
        r_pad  <= n_pad;
        r_fin  <= n_fin;
        r_last <= n_last;
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bv;
    assign o_pad_bits   = r_pad;
    assign o_is_final   = r_fin;
    assign o_last       = r_last;

endmodule

// ----- src/huffman_bit_pack_encoder_core.sv -----
// First byte of an encode or flush item: table read register, entry queue, then output register.
// Throughput: one input transaction per cycle while o_stall is low; the packer emits one byte per
// cycle unless held by i_stall; an item that completes k bytes (k up to 4) occupies it for all k.
// Reset: synchronous, active low; all table lengths read as absent at once through
// per-entry valid bits, with no clearing pass; the pending byte is emptied.
module huffman_bit_pack_encoder_core #(
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hbpe_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hbpe_pkg::FUNC_W-1:0]   i_func,
    input  logic [hbpe_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hbpe_pkg::LEN_IN_W-1:0] i_code_length,
    input  logic [hbpe_pkg::WORD_W-1:0]   i_code_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hbpe_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_byte_valid,
    output logic [hbpe_pkg::PAD_W-1:0]    o_pad_bits,
    output logic                          o_is_final,
    output logic                          o_last
);
    import hbpe_pkg::*;

    localparam int ENT_W = entry_w(MAX_CODE_LEN);

    logic             push;
    logic [ENT_W-1:0] entry;
    logic             q_full;
    logic             q_valid;
    logic [ENT_W-1:0] q_entry;
    logic             q_pop;

    hbpe_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_word   (i_code_word),
        .o_push        (push),
        .o_entry       (entry),
        .i_q_full      (q_full)
    );

    hbpe_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    hbpe_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_entry),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_pad_bits   (o_pad_bits),
        .o_is_final   (o_is_final),
        .o_last       (o_last)
    );

endmodule

// ----- src/hbpe_checker.sv -----
module hbpe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [hbpe_pkg::FUNC_W-1:0]   i_func,
    input logic [hbpe_pkg::SYM_W-1:0]    i_symbol,
    input logic [hbpe_pkg::LEN_IN_W-1:0] i_code_length,
    input logic [hbpe_pkg::WORD_W-1:0]   i_code_word,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [hbpe_pkg::BYTE_W-1:0]   o_out_byte,
    input logic                          o_byte_valid,
    input logic [hbpe_pkg::PAD_W-1:0]    o_pad_bits,
    input logic                          o_is_final,
    input logic                          o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_valid)
            && $stable(o_pad_bits) && $stable(o_is_final) && $stable(o_last))
        else $error("stalled result changed");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_is_final && o_last && (o_out_byte == '0)
            && (o_pad_bits == '0))
        else $error("empty result is not a clean empty flush");

    a_data_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_final |-> o_byte_valid && (o_pad_bits == '0))
        else $error("encoded byte carries padding or no data");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_final |-> o_last)
        else $error("flush result not marked last");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented after reset");

endmodule

bind huffman_bit_pack_encoder_core hbpe_checker u_hbpe_checker (.*);

// ----- tb/sv/huffman_bit_pack_encoder_core_tb.sv -----
module huffman_bit_pack_encoder_core_tb;
    import hbpe_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SYMS        = SYMBOL_COUNT_DEF;
    localparam int LEN_CAP     = (MAX_CODE_LEN_DEF < WORD_W) ? MAX_CODE_LEN_DEF : WORD_W;
    localparam int RANDOM_ITEMS = 260;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [PAD_W-1:0]  pad_bits;
        logic              is_final;
        logic              last;
    } t_coded_byte;

    class hbpe_byte_scoreboard;
        logic [LEN_IN_W-1:0] len_tab [SYMS];
        logic [WORD_W-1:0]   code_tab [SYMS];
        logic [BYTE_W-1:0]   acc_byte;
        logic [PAD_W-1:0]    fill_pos;
        t_coded_byte         coded_q [$];
        int                  errors;

        function new();
            for (int i = 0; i < SYMS; i++) begin
                len_tab[i]  = '0;
                code_tab[i] = '0;
            end
            acc_byte = '0;
            fill_pos = 3'd7;
            errors   = 0;
        endfunction

        function void emit(logic [BYTE_W-1:0] b, logic bv, logic [PAD_W-1:0] pad, logic fin);
            t_coded_byte r;
            r.out_byte   = b;
            r.byte_valid = bv;
            r.pad_bits   = pad;
            r.is_final   = fin;
            r.last       = 1'b0;
            coded_q = {coded_q, r};
        endfunction

        function void note_item(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] sym,
                                logic [LEN_IN_W-1:0] len, logic [WORD_W-1:0] word);
            int n;
            int k;
            n = 0;
            case (f)
                FUNC_LOAD: begin
                    if (sym < SYMS) begin
                        len_tab[sym]  = (len > LEN_CAP) ? LEN_IN_W'(LEN_CAP) : len;
                        code_tab[sym] = word;
                    end
                end
                FUNC_ENCODE: begin
                    if (sym < SYMS) begin
                        for (k = int'(len_tab[sym]); k > 0; k--) begin
                            acc_byte[fill_pos] = code_tab[sym][k-1];
                            if (fill_pos == 3'd0) begin
                                emit(acc_byte, 1'b1, 3'd0, 1'b0);
                                n++;
                                acc_byte = '0;
                                fill_pos = 3'd7;
                            end else begin
                                fill_pos = fill_pos - 3'd1;
                            end
                        end
                        if (n > 0)
                            coded_q[coded_q.size()-1].last = 1'b1;
                    end
                end
                FUNC_FLUSH: begin
                    if (fill_pos != 3'd7) begin
                        emit(acc_byte, 1'b1, fill_pos + 3'd1, 1'b1);
                        acc_byte = '0;
                        fill_pos = 3'd7;
                    end else begin
                        emit('0, 1'b0, 3'd0, 1'b1);
                    end
                    coded_q[coded_q.size()-1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_byte(t_coded_byte got);
            t_coded_byte want;
            if (coded_q.size() == 0) begin
                report($sformatf("unexpected output transaction %p", got));
            end else begin
                want = coded_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
                if (got.byte_valid !== want.byte_valid)
                    report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
                if (got.pad_bits !== want.pad_bits)
                    report($sformatf("pad_bits %0d, want %0d", got.pad_bits, want.pad_bits));
                if (got.is_final !== want.is_final)
                    report($sformatf("is_final %b, want %b", got.is_final, want.is_final));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask

        function int outstanding();
            return coded_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [SYM_W-1:0]    i_symbol;
    logic [LEN_IN_W-1:0] i_code_length;
    logic [WORD_W-1:0]   i_code_word;
    logic                o_valid;
    logic                i_stall;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_byte_valid;
    logic [PAD_W-1:0]    o_pad_bits;
    logic                o_is_final;
    logic                o_last;

    hbpe_byte_scoreboard sb;
    bit                  no_idle;
    bit                  long_hold_req;
    logic [SYM_W-1:0]    loaded_syms [$];

    huffman_bit_pack_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_word   (i_code_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_pad_bits    (o_pad_bits),
        .o_is_final    (o_is_final),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[huffman_bit_pack_encoder_core] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        t_coded_byte got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_item(i_func, i_symbol, i_code_length, i_code_word);
            if (o_valid && !i_stall) begin
                got.out_byte   = o_out_byte;
                got.byte_valid = o_byte_valid;
                got.pad_bits   = o_pad_bits;
                got.is_final   = o_is_final;
                got.last       = o_last;
                sb.check_byte(got);
            end
        end
    end

    // output side: random hold per transaction, plus one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] sym,
                             logic [LEN_IN_W-1:0] len, logic [WORD_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_func        <= f;
        i_symbol      <= sym;
        i_code_length <= len;
        i_code_word   <= word;
        do @(posedge i_clk); while (o_stall);
        if (f == FUNC_LOAD && len != '0)
            loaded_syms = {loaded_syms, sym};
    endtask

    task automatic send_random_item();
        int                  pick;
        logic [SYM_W-1:0]    sym;
        logic [LEN_IN_W-1:0] len;
        pick = $urandom_range(0, 99);
        sym  = SYM_W'($urandom_range(0, SYMS - 1));
        if (pick < 20 || loaded_syms.size() == 0) begin
            len = ($urandom_range(0, 4) == 0) ? LEN_IN_W'($urandom_range(0, 63))
                                              : LEN_IN_W'($urandom_range(1, 16));
            send_item(FUNC_LOAD, sym, len, $urandom());
        end else if (pick < 85) begin
            if ($urandom_range(0, 9) != 0)
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            send_item(FUNC_ENCODE, sym, LEN_IN_W'($urandom()), $urandom());
        end else if (pick < 95) begin
            send_item(FUNC_FLUSH, sym, LEN_IN_W'($urandom()), $urandom());
        end else begin
            send_item(FUNC_UNUSED, sym, LEN_IN_W'($urandom()), $urandom());
        end
    endtask

    initial begin
        int done;
        sb            = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = FUNC_LOAD;
        i_symbol      = '0;
        i_code_length = '0;
        i_code_word   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(FUNC_FLUSH,  8'h00, 6'd0,  32'h0);
        send_item(FUNC_ENCODE, 8'h00, 6'd0,  32'h0);
        send_item(FUNC_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF);
        send_item(FUNC_ENCODE, 8'h00, 6'd0,  32'h0);
        send_item(FUNC_LOAD,   8'hFF, 6'd32, 32'hA5C3_0FF0);
        send_item(FUNC_ENCODE, 8'hFF, 6'd0,  32'h0);
        send_item(FUNC_LOAD,   8'h01, 6'd63, 32'h8000_0001);
        send_item(FUNC_LOAD,   8'h02, 6'd3,  32'hFFFF_FFFD);
        send_item(FUNC_ENCODE, 8'h02, 6'd0,  32'h0);
        send_item(FUNC_ENCODE, 8'h01, 6'd0,  32'h0);
        send_item(FUNC_FLUSH,  8'hFF, 6'd63, 32'hFFFF_FFFF);
        send_item(FUNC_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF);
        send_item(FUNC_LOAD,   8'h80, 6'd1,  32'h1);
        send_item(FUNC_ENCODE, 8'h80, 6'd0,  32'h0);
        send_item(FUNC_FLUSH,  8'h00, 6'd0,  32'h0);
        send_item(FUNC_LOAD,   8'h55, 6'd7,  32'h55);
        send_item(FUNC_ENCODE, 8'h80, 6'd0,  32'h0);
        send_item(FUNC_ENCODE, 8'h55, 6'd0,  32'h0);
        send_item(FUNC_ENCODE, 8'h55, 6'd0,  32'h0);
        send_item(FUNC_FLUSH,  8'h00, 6'd0,  32'h0);
        send_item(FUNC_LOAD,   8'hAA, 6'd8,  32'h0);
        send_item(FUNC_ENCODE, 8'hAA, 6'd0,  32'h0);
        send_item(FUNC_FLUSH,  8'h00, 6'd0,  32'h0);

        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (done == 120) begin
                no_idle = 1'b1;
                send_item(FUNC_LOAD, 8'h7E, 6'd32, $urandom());
                long_hold_req = 1'b1;
                repeat (30) send_item(FUNC_ENCODE, 8'h7E, 6'd0, 32'h0);
                no_idle = 1'b0;
                done += 31;
            end else begin
                send_random_item();
                if (i_func != FUNC_UNUSED)
                    done++;
            end
        end
        send_item(FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[huffman_bit_pack_encoder_core] OK");
        else
            $display("[huffman_bit_pack_encoder_core] ERROR");
        $finish;
    end

endmodule
